@@ sv/abr_pkg.sv @@
// ----------------------------------------------------------------------------
// abr_pkg
// Types, register indexes, reset values and helpers for the bit reservoir.
// ----------------------------------------------------------------------------
package abr_pkg;

	typedef enum logic [1:0] {
		CMD_FRAME_BEGIN = 2'd0,
		CMD_GRANULE     = 2'd1,
		CMD_FRAME_END   = 2'd2
	} cmd_t;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GRANULES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIDE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISABLE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAXBUF   = 2'd3;

	localparam logic [1:0]  GRANULES_RST = 2'd2;
	localparam logic [5:0]  SIDE_RST     = 6'd32;
	localparam logic [15:0] MAXBUF_RST   = 16'd11520;

	// reservoir cap from the main-data pointer range
	localparam logic [12:0] CAP_ONE_GR = 13'd2040;
	localparam logic [12:0] CAP_TWO_GR = 13'd4088;

	localparam logic [7:0] SHAPE_FULL = 8'h80;
	localparam logic [7:0] SHAPE_MASK = 8'h7f;

	// floor(x / 10), exact for x below 81920
	function automatic logic [14:0] div10(input logic [16:0] x);
		logic [33:0] p;
		p = {17'd0, x} * 34'd52429;
		return p[33:19];
	endfunction

endpackage

@@ sv/audio_bit_reservoir_top.sv @@
// ----------------------------------------------------------------------------
// audio_bit_reservoir_top
// Layer III bit reservoir: size and maximum, frame and granule budgeting.
// ----------------------------------------------------------------------------
// Takes one item per clock while item_stall is low and returns one result
// per item: the item register feeds a single pass of budget logic whose
// result and the updated reservoir state are captured together, so the next
// item sees the state left by this one. A stalled result register holds
// while the item register still takes one more item.
module audio_bit_reservoir_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [abr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [abr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    cmd,
	input  logic [15:0]                   frame_bits,
	input  logic signed [16:0]            value_bits,
	input  logic [7:0]                    shaping_in,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [15:0]                   granule_share,
	output logic [15:0]                   full_frame_bits,
	output logic signed [17:0]            target_bits,
	output logic [15:0]                   borrow_bits,
	output logic [7:0]                    shaping_out,
	output logic [15:0]                   drain_bits,
	output logic signed [15:0]            reservoir_size,
	output logic [11:0]                   reservoir_max
);

	logic [1:0]  granules_q;
	logic [5:0]  side_q;
	logic        disabled_q;
	logic [15:0] maxbuf_q;

	logic signed [15:0] size_q;
	logic [12:0]        limit_q;

	logic               valid_s1;
	abr_pkg::cmd_t      cmd_s1;
	logic [15:0]        frame_s1;
	logic signed [16:0] value_s1;
	logic [7:0]         shaping_s1;

	logic result_valid_q;
	logic advance;

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granules_q <= abr_pkg::GRANULES_RST;
			side_q     <= abr_pkg::SIDE_RST;
			disabled_q <= 1'b0;
			maxbuf_q   <= abr_pkg::MAXBUF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				abr_pkg::REG_GRANULES: granules_q <= cfg_data[1:0];
				abr_pkg::REG_SIDE:     side_q     <= cfg_data[5:0];
				abr_pkg::REG_DISABLE:  disabled_q <= cfg_data[0];
				abr_pkg::REG_MAXBUF:   maxbuf_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1     <= abr_pkg::cmd_t'(cmd);
			frame_s1   <= frame_bits;
			value_s1   <= value_bits;
			shaping_s1 <= shaping_in;
		end
	end

	// frame begin
	logic               two_gr;
	logic signed [17:0] payload;
	logic [15:0]        fb_mean;
	logic [16:0]        fb_whole;
	logic signed [17:0] fb_room;
	logic [12:0]        fb_cap;
	logic [12:0]        fb_limit;
	logic signed [16:0] fb_sel;
	logic signed [18:0] fb_full;
	logic [15:0]        fb_full_c;

	// granule
	logic signed [20:0] size_x10;
	logic [15:0]        lim_x6;
	logic [15:0]        lim_x9;
	logic [14:0]        q6;
	logic [14:0]        q9;
	logic               fill60;
	logic               fill90;
	logic signed [17:0] gr_add;
	logic signed [18:0] gr_avail;
	logic [16:0]        gr_mag;
	logic [14:0]        gr_q;
	logic signed [17:0] gr_cut;
	logic signed [18:0] gr_target;
	logic [15:0]        gr_extra;
	logic [7:0]         gr_shape;

	// frame end
	logic signed [17:0] fe_sum;
	logic signed [17:0] fe_aligned;
	logic signed [17:0] fe_stuff;
	logic signed [15:0] fe_size;
	logic [15:0]        fe_drain;

	always_comb begin
		two_gr   = granules_q[1];
		payload  = $signed({2'b00, frame_s1}) - $signed({9'd0, side_q, 3'b000});
		fb_mean  = payload[17] ? 16'd0 : (two_gr ? payload[16:1] : payload[15:0]);
		fb_whole = two_gr ? {fb_mean, 1'b0} : {1'b0, fb_mean};
		fb_room  = $signed({2'b00, maxbuf_q}) - $signed({2'b00, frame_s1});
		fb_cap   = two_gr ? abr_pkg::CAP_TWO_GR : abr_pkg::CAP_ONE_GR;
		if (fb_room[17] || disabled_q) begin
			fb_limit = 13'd0;
		end else if (fb_room > $signed({5'd0, fb_cap})) begin
			fb_limit = fb_cap;
		end else begin
			fb_limit = {fb_room[12:3], 3'b000};
		end
		fb_sel  = ($signed({size_q[15], size_q}) < $signed({4'd0, fb_limit})) ?
			$signed({size_q[15], size_q}) : $signed({4'd0, fb_limit});
		fb_full = $signed({2'b00, fb_whole}) + 19'(fb_sel);
		if (fb_full[18]) begin
			fb_full_c = 16'd0;
		end else if (fb_full > $signed({3'b000, maxbuf_q})) begin
			fb_full_c = maxbuf_q;
		end else begin
			fb_full_c = fb_full[15:0];
		end

		size_x10 = 21'(size_q) * 21'sd10;
		lim_x6   = 16'(limit_q) * 16'd6;
		lim_x9   = 16'(limit_q) * 16'd9;
		q6       = abr_pkg::div10({1'b0, lim_x6});
		q9       = abr_pkg::div10({1'b0, lim_x9});
		fill60   = size_x10 >= $signed({5'd0, lim_x6});
		fill90   = size_x10 >= $signed({5'd0, lim_x9});
		gr_add   = fill90 ? (18'(size_q) - $signed({3'b000, q9})) : 18'sd0;
		gr_avail = $signed({4'd0, q6}) - 19'(gr_add);
		gr_mag   = value_s1[16] ? 17'(-value_s1) : value_s1;
		gr_q     = abr_pkg::div10(gr_mag);
		gr_cut   = 18'(value_s1) -
			(value_s1[16] ? -$signed({3'b000, gr_q}) : $signed({3'b000, gr_q}));
		if (fill60) begin
			gr_target = 19'(value_s1) + 19'(gr_add);
			gr_extra  = gr_avail[18] ? 16'd0 : gr_avail[15:0];
			gr_shape  = fill90 ? (shaping_s1 | abr_pkg::SHAPE_FULL) : shaping_s1;
		end else begin
			gr_target = shaping_s1[0] ? 19'(value_s1) : 19'(gr_cut);
			gr_extra  = size_q;
			gr_shape  = shaping_s1 & abr_pkg::SHAPE_MASK;
		end

		fe_sum     = 18'(size_q) + 18'(value_s1);
		fe_aligned = {fe_sum[17:3], 3'b000};
		if (fe_sum[17]) begin
			fe_size  = (fe_sum < -18'sd32768) ? -16'sd32768 : fe_sum[15:0];
			fe_stuff = 18'sd0;
		end else if (fe_aligned > $signed({5'd0, limit_q})) begin
			fe_size  = $signed({3'b000, limit_q});
			fe_stuff = fe_sum - $signed({5'd0, limit_q});
		end else begin
			fe_size  = fe_aligned[15:0];
			fe_stuff = {15'd0, fe_sum[2:0]};
		end
		fe_drain = fe_stuff[16] ? 16'hffff : fe_stuff[15:0];
	end

	// result register and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			size_q         <= 16'sd0;
			limit_q        <= 13'd0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
			if (valid_s1) begin
				case (cmd_s1)
					abr_pkg::CMD_FRAME_BEGIN: limit_q <= fb_limit;
					abr_pkg::CMD_FRAME_END:   size_q  <= fe_size;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			granule_share   <= 16'd0;
			full_frame_bits <= 16'd0;
			target_bits     <= 18'sd0;
			borrow_bits     <= 16'd0;
			shaping_out     <= shaping_s1;
			drain_bits      <= 16'd0;
			reservoir_size  <= size_q;
			reservoir_max   <= limit_q[11:0];
			case (cmd_s1)
				abr_pkg::CMD_FRAME_BEGIN: begin
					granule_share   <= fb_mean;
					full_frame_bits <= fb_full_c;
					reservoir_max   <= fb_limit[11:0];
				end
				abr_pkg::CMD_GRANULE: begin
					target_bits <= gr_target[17:0];
					borrow_bits <= gr_extra;
					shaping_out <= gr_shape;
				end
				abr_pkg::CMD_FRAME_END: begin
					drain_bits     <= fe_drain;
					reservoir_size <= fe_size;
				end
				default: ;
			endcase
		end
	end

	assign result_valid = result_valid_q;

endmodule

@@ verif/audio_bit_reservoir_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_bit_reservoir_top_tb
// Self-checking bench for the Layer III bit reservoir. A scoreboard class
// keeps its own copy of the reservoir state and registers and predicts each
// budget result. Directed corner events come first, then frames of random
// content under several register settings. Both sides idle and stall at
// random, and the checker compares every result field by field, in order.
// ----------------------------------------------------------------------------
module audio_bit_reservoir_top_tb;
	import abr_pkg::*;

	typedef struct {
		logic [15:0]        mean;
		logic [15:0]        full;
		logic signed [17:0] target;
		logic [15:0]        extra;
		logic [7:0]         shape;
		logic [15:0]        drain;
		logic signed [15:0] size;
		logic [11:0]        maxr;
	} budget_t;

	class reservoir_board;
		longint  granules, side, disabled, maxbuf;
		longint  res_bits, res_lim;
		budget_t budget_q[$];
		int      errors;

		function new();
			granules = longint'(GRANULES_RST);
			side     = longint'(SIDE_RST);
			disabled = 0;
			maxbuf   = longint'(MAXBUF_RST);
			res_bits = 0;
			res_lim  = 0;
			errors   = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GRANULES: granules = longint'(data[1:0]);
				REG_SIDE:     side     = longint'(data[5:0]);
				REG_DISABLE:  disabled = longint'(data[0]);
				REG_MAXBUF:   maxbuf   = longint'(data);
				default: ;
			endcase
		endfunction

		// predict the budget for one accepted item and update the state
		function void take_event(logic [1:0] c, logic [15:0] f, logic signed [16:0] v,
				logic [7:0] s);
			longint  g, frame, val, sz, lm, m, r, cap, full, extra, add, sum, stuff, over;
			longint  drain;
			logic [7:0] shp;
			budget_t e;
			g     = (granules >= 2) ? 2 : 1;
			frame = longint'(f);
			val   = longint'(v);
			shp   = s;
			sz    = res_bits;
			lm    = res_lim;
			e.mean   = '0;
			e.full   = '0;
			e.target = '0;
			e.extra  = '0;
			e.drain  = '0;
			case (c)
				CMD_FRAME_BEGIN: begin
					cap = 2048 * g - 8;
					m = (frame - side * 8) / g;
					if (m < 0) m = 0;
					r = maxbuf - frame;
					if (r > cap) r = cap;
					if (r < 0 || disabled != 0) r = 0;
					r = (r / 8) * 8;
					res_lim = r;
					lm = r;
					full = m * g + ((sz < lm) ? sz : lm);
					if (full > maxbuf) full = maxbuf;
					if (full < 0) full = 0;
					e.mean = m[15:0];
					e.full = full[15:0];
				end
				CMD_GRANULE: begin
					m = val;
					extra = sz;
					if (sz * 10 >= lm * 6) begin
						add = 0;
						if (sz * 10 >= lm * 9) begin
							add = sz - (lm * 9) / 10;
							m = m + add;
							shp = shp | SHAPE_FULL;
						end
						extra = (lm * 6) / 10 - add;
						if (extra < 0) extra = 0;
					end else begin
						if (!shp[0]) m = m - m / 10;
						shp = shp & SHAPE_MASK;
					end
					e.target = m[17:0];
					e.extra  = extra[15:0];
				end
				CMD_FRAME_END: begin
					sum = sz + val;
					if (sum < 0) begin
						if (sum < -32768) sum = -32768;
						res_bits = sum;
					end else begin
						stuff = sum % 8;
						over = (sum - stuff) - lm;
						if (over > 0) stuff = stuff + over;
						res_bits = sum - stuff;
						drain = (stuff > 65535) ? 65535 : stuff;
						e.drain = drain[15:0];
					end
				end
				default: ;
			endcase
			e.shape = shp;
			e.size  = res_bits[15:0];
			e.maxr  = res_lim[11:0];
			budget_q.push_back(e);
		endfunction

		function void cmp(string nm, longint want, longint got);
			if (want != got) begin
				$display("%0t mismatch %s: expected %0d, actual %0d", $time, nm, want, got);
				errors++;
			end
		endfunction

		function void match_budget(logic [15:0] mean, logic [15:0] full,
				logic signed [17:0] target, logic [15:0] extra, logic [7:0] shape,
				logic [15:0] drain, logic signed [15:0] size, logic [11:0] maxr);
			budget_t e;
			if (budget_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual size %0d", $time, size);
				errors++;
			end else begin
				e = budget_q.pop_front();
				cmp("granule_share", longint'(e.mean), longint'(mean));
				cmp("full_frame_bits", longint'(e.full), longint'(full));
				cmp("target_bits", longint'(e.target), longint'(target));
				cmp("borrow_bits", longint'(e.extra), longint'(extra));
				cmp("shaping_out", longint'(e.shape), longint'(shape));
				cmp("drain_bits", longint'(e.drain), longint'(drain));
				cmp("reservoir_size", longint'(e.size), longint'(size));
				cmp("reservoir_max", longint'(e.maxr), longint'(maxr));
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n       = 1'b0;
	logic                   cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index    = '0;
	logic [CFG_DATA_W-1:0]  cfg_data     = '0;
	logic                   item_valid   = 1'b0;
	logic                   item_stall;
	logic [1:0]             cmd          = '0;
	logic [15:0]            frame_bits   = '0;
	logic signed [16:0]     value_bits   = '0;
	logic [7:0]             shaping_in   = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	logic [15:0]            granule_share;
	logic [15:0]            full_frame_bits;
	logic signed [17:0]     target_bits;
	logic [15:0]            borrow_bits;
	logic [7:0]             shaping_out;
	logic [15:0]            drain_bits;
	logic signed [15:0]     reservoir_size;
	logic [11:0]            reservoir_max;

	reservoir_board board;
	int  send_idle  = 29;
	int  recv_idle  = 57;
	int  phase_sent = 0;
	bit  hold_req   = 1'b0;
	int  hold_left  = 0;

	audio_bit_reservoir_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// result side: check accepted results, then pick next stall
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			board.match_budget(granule_share, full_frame_bits, target_bits, borrow_bits,
				shaping_out, drain_bits, reservoir_size, reservoir_max);
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 80;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic send_item(logic [1:0] c, logic [15:0] f, logic signed [16:0] v,
			logic [7:0] s);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		frame_bits <= f;
		value_bits <= v;
		shaping_in <= s;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		board.take_event(c, f, v, s);
		phase_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (board.budget_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	function automatic logic signed [16:0] rand_value();
		return 17'($urandom);
	endfunction

	// one well-formed frame: begin, a granule per granule slot, end
	task automatic send_frame();
		int g;
		logic [15:0] f;
		logic signed [16:0] v;
		g = (board.granules >= 2) ? 2 : 1;
		if ($urandom_range(3) == 0)
			f = 16'($urandom);
		else
			f = 16'(int'(board.side) * 8 + int'($urandom_range(100, 3000)));
		send_item(CMD_FRAME_BEGIN, f, rand_value(), 8'($urandom));
		for (int i = 0; i < g; i++) begin
			if ($urandom_range(9) == 0) v = rand_value();
			else v = 17'(int'($urandom_range(0, 4000)));
			send_item(CMD_GRANULE, 16'($urandom), v, 8'($urandom));
		end
		if ($urandom_range(9) == 0) v = rand_value();
		else v = 17'(int'($urandom_range(0, 4000)) - 1000);
		send_item(CMD_FRAME_END, 16'($urandom), v, 8'($urandom));
	endtask

	initial begin
		logic [1:0]  gr_v;
		logic [5:0]  side_v;
		logic        dis_v;
		logic [15:0] maxbuf_v;
		bit          held;
		bit          paused;
		board = new();
		held = 1'b0;
		paused = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner events under reset settings
		send_item(CMD_GRANULE, 16'd0, 17'sd0, 8'h00);
		send_item(2'd3, 16'hffff, -17'sd1, 8'hff);
		send_item(CMD_FRAME_BEGIN, 16'd0, 17'sd0, 8'h55);
		send_item(CMD_GRANULE, 16'd0, 17'sd65535, 8'h00);
		send_item(CMD_GRANULE, 16'd0, -17'sd65536, 8'h01);
		send_item(CMD_FRAME_END, 16'd0, 17'sd2870, 8'haa);
		send_item(CMD_GRANULE, 16'd0, 17'sd1000, 8'h81);
		send_item(CMD_FRAME_END, 16'd0, 17'sd65535, 8'h00);
		send_item(CMD_GRANULE, 16'd0, 17'sd500, 8'h00);
		send_item(CMD_FRAME_BEGIN, 16'd10005, 17'sd0, 8'h00);
		send_item(CMD_FRAME_BEGIN, 16'hffff, 17'sd0, 8'h00);
		send_item(CMD_FRAME_END, 16'd0, 17'sd65535, 8'h00);
		send_item(CMD_FRAME_END, 16'd0, -17'sd65536, 8'h00);
		send_item(CMD_GRANULE, 16'd0, -17'sd1000, 8'h00);
		send_item(CMD_FRAME_BEGIN, 16'd100, 17'sd0, 8'h00);
		send_item(CMD_FRAME_END, 16'd0, 17'sd65535, 8'h00);
		send_item(CMD_GRANULE, 16'd0, 17'sd65535, 8'hfe);
		send_item(CMD_FRAME_END, 16'd0, 17'sd0, 8'h00);
		send_item(CMD_FRAME_BEGIN, 16'd11520, 17'sd0, 8'h00);
		send_item(CMD_GRANULE, 16'd0, 17'sd0, 8'h7f);

		for (int ph = 0; ph < 8; ph++) begin
			settle();
			case (ph)
				0: begin gr_v = 2'd1; side_v = 6'd17; dis_v = 1'b0; maxbuf_v = 16'd11520; end
				1: begin gr_v = 2'd0; side_v = 6'd0;  dis_v = 1'b0; maxbuf_v = 16'hffff; end
				2: begin gr_v = 2'd3; side_v = 6'd63; dis_v = 1'b1; maxbuf_v = 16'd0; end
				3: begin gr_v = 2'd2; side_v = 6'd32; dis_v = 1'b0; maxbuf_v = 16'd4608; end
				default: begin
					gr_v   = 2'($urandom);
					side_v = 6'($urandom);
					dis_v  = ($urandom_range(3) == 0);
					if ($urandom_range(1) == 0) maxbuf_v = 16'($urandom_range(4000, 14000));
					else maxbuf_v = 16'($urandom);
				end
			endcase
			write_reg(REG_GRANULES, CFG_DATA_W'(gr_v));
			write_reg(REG_SIDE, CFG_DATA_W'(side_v));
			write_reg(REG_DISABLE, CFG_DATA_W'(dis_v));
			write_reg(REG_MAXBUF, maxbuf_v);
			cfg_we <= 1'b0;
			if (ph < 3) begin
				send_idle = 29;
				recv_idle = 57;
			end else if (ph < 6) begin
				send_idle = 57;
				recv_idle = 29;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			phase_sent = 0;
			while (phase_sent < 180) begin
				if (ph == 1 && !held && phase_sent >= 50) begin
					held = 1'b1;
					hold_req = 1'b1;
				end
				if (ph == 4 && !paused && phase_sent >= 60) begin
					paused = 1'b1;
					settle();
				end
				if ($urandom_range(99) < 80)
					send_frame();
				else
					send_item(2'($urandom), 16'($urandom), rand_value(), 8'($urandom));
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (board.budget_q.size() != 0)
			$display("%0t missing results: expected %0d more, actual 0",
				$time, board.budget_q.size());
		if (board.errors == 0 && board.budget_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
